/* hdl/utf8_stream_validator_assert.svh */
// Assertion macros for the UTF-8 stream validator.
`ifndef UTF8_STREAM_VALIDATOR_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U8SV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8 stream validator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define U8SV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8 stream validator assertion failed");

`endif

/* hdl/u8sv_pkg.sv */
package u8sv_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_content;
    } in_t;

    typedef struct packed {
        logic       content_valid;
        logic [1:0] mark_length;
    } out_t;

    localparam int ACCUM_W = 21;

    localparam logic [7:0] ASCII_MAX   = 8'h7F;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_CODE  = 8'hF0;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_CODE   = 8'h80;
    localparam logic [7:0] MARK_BYTE0  = 8'hEF;
    localparam logic [7:0] MARK_BYTE1  = 8'hBB;
    localparam logic [7:0] MARK_BYTE2  = 8'hBF;
    localparam logic [1:0] MARK_COUNT  = 2'd3;
    localparam logic [1:0] MARK_LEN    = 2'd3;

    localparam logic [1:0] FORM_TWO    = 2'd1;
    localparam logic [1:0] FORM_THREE  = 2'd2;
    localparam logic [1:0] FORM_FOUR   = 2'd3;

    localparam logic [ACCUM_W-1:0] MIN_TWO   = 21'h00080;
    localparam logic [ACCUM_W-1:0] MAX_TWO   = 21'h007FF;
    localparam logic [ACCUM_W-1:0] MIN_THREE = 21'h00800;
    localparam logic [ACCUM_W-1:0] MAX_THREE = 21'h0FFFF;
    localparam logic [ACCUM_W-1:0] MIN_FOUR  = 21'h10000;
    localparam logic [ACCUM_W-1:0] MAX_FOUR  = 21'h10FFFF;
    localparam logic [ACCUM_W-1:0] MAX_ONE   = 21'h0007F;

    function automatic logic [7:0] mark_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = MARK_BYTE0;
            2'd1:    b = MARK_BYTE1;
            2'd2:    b = MARK_BYTE2;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic in_range(input logic [1:0] form,
                                      input logic [ACCUM_W-1:0] cp);
        logic ok;
        case (form)
            FORM_TWO:   ok = (cp >= MIN_TWO) && (cp <= MAX_TWO);
            FORM_THREE: ok = (cp >= MIN_THREE) && (cp <= MAX_THREE);
            FORM_FOUR:  ok = (cp >= MIN_FOUR) && (cp <= MAX_FOUR);
            default:    ok = (cp <= MAX_ONE);
        endcase
        return ok;
    endfunction

endpackage

/* hdl/utf8_stream_validator.sv */
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_data (in_t): byte, present flag, end flag
// m_        out        m_valid / m_ready  m_data (out_t): validity, mark length
//
// One request per cycle while s_ready; m_valid is high the cycle after the end flag.
// The decode step and mark check are one pass of logic ahead of the state registers.
// A held result stalls input only when m_ready is low; otherwise input flows each cycle.
// Synchronous active-low reset clears the decoder state and m_valid but not m_data.
`include "utf8_stream_validator_assert.svh"

module utf8_stream_validator (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  u8sv_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output u8sv_pkg::out_t m_data
);

    logic [1:0]                   bytes_left_reg, bytes_left_next;
    logic [u8sv_pkg::ACCUM_W-1:0] code_accum_reg, code_accum_next;
    logic [1:0]                   form_class_reg, form_class_next;
    logic                         error_seen_reg, error_seen_next;
    logic [1:0]                   start_count_reg, start_count_next;
    logic                         mark_match_reg, mark_match_next;
    logic                         out_valid_reg, out_valid_next;
    u8sv_pkg::out_t               out_data_reg, out_data_next;
    logic                         accept;
    logic [7:0]                   b;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.data_byte;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        bytes_left_next  = bytes_left_reg;
        code_accum_next  = code_accum_reg;
        form_class_next  = form_class_reg;
        error_seen_next  = error_seen_reg;
        start_count_next = start_count_reg;
        mark_match_next  = mark_match_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_data_next    = out_data_reg;

        if (accept) begin
            if (s_data.byte_present) begin
                if (start_count_reg != u8sv_pkg::MARK_COUNT) begin
                    if (b != u8sv_pkg::mark_byte(start_count_reg)) begin
                        mark_match_next = 1'b0;
                    end
                    start_count_next = start_count_reg + 2'd1;
                end
                if (!error_seen_reg) begin
                    if (bytes_left_reg == 2'd0) begin
                        if (b <= u8sv_pkg::ASCII_MAX) begin
                            bytes_left_next = 2'd0;
                        end else if ((b & u8sv_pkg::LEAD2_MASK) == u8sv_pkg::LEAD2_CODE) begin
                            bytes_left_next = 2'd1;
                            form_class_next = u8sv_pkg::FORM_TWO;
                            code_accum_next = {16'd0, b[4:0]};
                        end else if ((b & u8sv_pkg::LEAD3_MASK) == u8sv_pkg::LEAD3_CODE) begin
                            bytes_left_next = 2'd2;
                            form_class_next = u8sv_pkg::FORM_THREE;
                            code_accum_next = {17'd0, b[3:0]};
                        end else if ((b & u8sv_pkg::LEAD4_MASK) == u8sv_pkg::LEAD4_CODE) begin
                            bytes_left_next = 2'd3;
                            form_class_next = u8sv_pkg::FORM_FOUR;
                            code_accum_next = {18'd0, b[2:0]};
                        end else begin
                            error_seen_next = 1'b1;
                        end
                    end else if ((b & u8sv_pkg::CONT_MASK) != u8sv_pkg::CONT_CODE) begin
                        error_seen_next = 1'b1;
                        bytes_left_next = 2'd0;
                    end else begin
                        code_accum_next = {code_accum_reg[u8sv_pkg::ACCUM_W-7:0], b[5:0]};
                        bytes_left_next = bytes_left_reg - 2'd1;
                        if (bytes_left_reg == 2'd1 &&
                            !u8sv_pkg::in_range(form_class_reg, code_accum_next)) begin
                            error_seen_next = 1'b1;
                        end
                    end
                end
            end
            if (s_data.end_of_content) begin
                out_valid_next              = 1'b1;
                out_data_next.content_valid = !error_seen_next && (bytes_left_next == 2'd0);
                out_data_next.mark_length   =
                    (start_count_next == u8sv_pkg::MARK_COUNT && mark_match_next) ?
                    u8sv_pkg::MARK_LEN : 2'd0;
                bytes_left_next  = 2'd0;
                code_accum_next  = '0;
                form_class_next  = 2'd0;
                error_seen_next  = 1'b0;
                start_count_next = 2'd0;
                mark_match_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg  <= 2'd0;
            code_accum_reg  <= '0;
            form_class_reg  <= 2'd0;
            error_seen_reg  <= 1'b0;
            start_count_reg <= 2'd0;
            mark_match_reg  <= 1'b1;
            out_valid_reg   <= 1'b0;
        end else begin
            bytes_left_reg  <= bytes_left_next;
            code_accum_reg  <= code_accum_next;
            form_class_reg  <= form_class_next;
            error_seen_reg  <= error_seen_next;
            start_count_reg <= start_count_next;
            mark_match_reg  <= mark_match_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    `U8SV_ASSERT_NEXT(a_end_gives_result, aclk, aresetn,
        accept && s_data.end_of_content, m_valid)
    `U8SV_ASSERT_SAME(a_left_within_form, aclk, aresetn,
        bytes_left_reg != 2'd0, bytes_left_reg <= form_class_reg)
    `U8SV_ASSERT_SAME(a_no_decode_after_error, aclk, aresetn,
        error_seen_reg, bytes_left_reg == 2'd0)

endmodule

/* verif/tb_utf8_stream_validator.sv */
`timescale 1ns / 100ps

module tb_utf8_stream_validator;

    typedef enum int {END_ON_BYTE, END_APART, END_EITHER} end_style_t;
    typedef enum int {FLAW_TRUNCATE, FLAW_OVERLONG, FLAW_TOO_HIGH, FLAW_SMASH, FLAW_STRAY,
                      FLAW_NONE} flaw_t;
    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_MOSTLY} sink_mode_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    u8sv_pkg::in_t  s_data = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    u8sv_pkg::out_t m_data;

    utf8_stream_validator u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #10 aclk = ~aclk;

    u8sv_pkg::in_t  pending_q[$];
    u8sv_pkg::out_t verdict_q[$];
    logic [7:0]     content_q[$];
    int unsigned    byte_steps = 0;
    int             fails = 0;
    logic           req_fire = 1'b0;

    // Decoder shadow state.
    logic [1:0]  cont_left = 2'd0;
    logic [20:0] cp_acc = '0;
    logic [1:0]  lead_form = 2'd0;
    logic        bad_seen = 1'b0;
    logic [1:0]  head_count = 2'd0;
    logic        mark_ok = 1'b1;

    task automatic track_utf8(input u8sv_pkg::in_t req);
        logic [7:0]     b;
        logic [7:0]     want;
        u8sv_pkg::out_t verdict;
        b = req.data_byte;
        if (req.byte_present) begin
            if (head_count < u8sv_pkg::MARK_COUNT) begin
                case (head_count)
                    2'd0:    want = u8sv_pkg::MARK_BYTE0;
                    2'd1:    want = u8sv_pkg::MARK_BYTE1;
                    default: want = u8sv_pkg::MARK_BYTE2;
                endcase
                if (b != want) mark_ok = 1'b0;
                head_count = head_count + 2'd1;
            end
            if (!bad_seen) begin
                if (cont_left == 2'd0) begin
                    if (b <= u8sv_pkg::ASCII_MAX) begin
                    end else if ((b & u8sv_pkg::LEAD2_MASK) == u8sv_pkg::LEAD2_CODE) begin
                        cont_left = 2'd1;
                        lead_form = u8sv_pkg::FORM_TWO;
                        cp_acc = 21'(b[4:0]);
                    end else if ((b & u8sv_pkg::LEAD3_MASK) == u8sv_pkg::LEAD3_CODE) begin
                        cont_left = 2'd2;
                        lead_form = u8sv_pkg::FORM_THREE;
                        cp_acc = 21'(b[3:0]);
                    end else if ((b & u8sv_pkg::LEAD4_MASK) == u8sv_pkg::LEAD4_CODE) begin
                        cont_left = 2'd3;
                        lead_form = u8sv_pkg::FORM_FOUR;
                        cp_acc = 21'(b[2:0]);
                    end else begin
                        bad_seen = 1'b1;
                    end
                end else if ((b & u8sv_pkg::CONT_MASK) != u8sv_pkg::CONT_CODE) begin
                    bad_seen = 1'b1;
                    cont_left = 2'd0;
                end else begin
                    cp_acc = {cp_acc[14:0], b[5:0]};
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 2'd0) begin
                        case (lead_form)
                            u8sv_pkg::FORM_TWO:   bad_seen = cp_acc < u8sv_pkg::MIN_TWO ||
                                                             cp_acc > u8sv_pkg::MAX_TWO;
                            u8sv_pkg::FORM_THREE: bad_seen = cp_acc < u8sv_pkg::MIN_THREE ||
                                                             cp_acc > u8sv_pkg::MAX_THREE;
                            u8sv_pkg::FORM_FOUR:  bad_seen = cp_acc < u8sv_pkg::MIN_FOUR ||
                                                             cp_acc > u8sv_pkg::MAX_FOUR;
                            default:              bad_seen = cp_acc > u8sv_pkg::MAX_ONE;
                        endcase
                    end
                end
            end
        end
        if (req.end_of_content) begin
            verdict.content_valid = !bad_seen && cont_left == 2'd0;
            verdict.mark_length = (head_count == u8sv_pkg::MARK_COUNT && mark_ok) ?
                                  u8sv_pkg::MARK_LEN : 2'd0;
            verdict_q.push_back(verdict);
            cont_left = 2'd0;
            cp_acc = '0;
            lead_form = 2'd0;
            bad_seen = 1'b0;
            head_count = 2'd0;
            mark_ok = 1'b1;
        end
    endtask

    task automatic add_step(input logic [7:0] b, input logic present, input logic last);
        u8sv_pkg::in_t req;
        req.data_byte = b;
        req.byte_present = present;
        req.end_of_content = last;
        pending_q.push_back(req);
        if (present || last) byte_steps++;
    endtask

    task automatic emit_content(input end_style_t style);
        logic ride;
        ride = (style == END_ON_BYTE) || (style == END_EITHER && $urandom_range(0, 1) == 1);
        if (content_q.size() == 0) ride = 1'b0;
        foreach (content_q[i]) begin
            if ($urandom_range(0, 11) == 0) add_step(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            add_step(content_q[i], 1'b1, ride && i == content_q.size() - 1);
        end
        if (!ride) add_step(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    function automatic void form_bounds(input int nbytes, output logic [20:0] lo,
                                        output logic [20:0] hi);
        case (nbytes)
            1: begin lo = '0;                  hi = u8sv_pkg::MAX_ONE;   end
            2: begin lo = u8sv_pkg::MIN_TWO;   hi = u8sv_pkg::MAX_TWO;   end
            3: begin lo = u8sv_pkg::MIN_THREE; hi = u8sv_pkg::MAX_THREE; end
            default: begin lo = u8sv_pkg::MIN_FOUR; hi = u8sv_pkg::MAX_FOUR; end
        endcase
    endfunction

    function automatic logic [20:0] pick_cp(input int nbytes);
        logic [20:0] lo;
        logic [20:0] hi;
        form_bounds(nbytes, lo, hi);
        case ($urandom_range(0, 7))
            0:       return lo;
            1:       return hi;
            default: return 21'($urandom_range(hi, lo));
        endcase
    endfunction

    task automatic put_cp(input int nbytes, input logic [20:0] cp);
        case (nbytes)
            1: content_q.push_back({1'b0, cp[6:0]});
            2: begin
                content_q.push_back({3'b110, cp[10:6]});
                content_q.push_back({2'b10, cp[5:0]});
            end
            3: begin
                content_q.push_back({4'b1110, cp[15:12]});
                content_q.push_back({2'b10, cp[11:6]});
                content_q.push_back({2'b10, cp[5:0]});
            end
            default: begin
                content_q.push_back({5'b11110, cp[20:18]});
                content_q.push_back({2'b10, cp[17:12]});
                content_q.push_back({2'b10, cp[11:6]});
                content_q.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic build_content();
        int          nbytes;
        int          pick;
        logic [20:0] lo;
        logic [20:0] hi;
        logic [7:0]  stray;
        flaw_t       flaw;
        content_q.delete();
        if ($urandom_range(0, 3) == 0) begin
            content_q.push_back(u8sv_pkg::MARK_BYTE0);
            content_q.push_back(u8sv_pkg::MARK_BYTE1);
            content_q.push_back(u8sv_pkg::MARK_BYTE2);
        end
        repeat ($urandom_range(0, 6)) begin
            nbytes = $urandom_range(1, 4);
            put_cp(nbytes, pick_cp(nbytes));
        end
        pick = $urandom_range(0, 11);
        flaw = (pick > 4) ? FLAW_NONE : flaw_t'(pick);
        case (flaw)
            FLAW_TRUNCATE: if (content_q.size() != 0) void'(content_q.pop_back());
            FLAW_OVERLONG: begin
                nbytes = $urandom_range(2, 4);
                form_bounds(nbytes, lo, hi);
                put_cp(nbytes, 21'($urandom_range(0, lo - 1)));
            end
            FLAW_TOO_HIGH: put_cp(4, 21'($urandom_range(21'h1FFFFF, 21'h110000)));
            FLAW_SMASH: if (content_q.size() != 0)
                content_q[$urandom_range(0, content_q.size() - 1)] = 8'($urandom_range(0, 255));
            FLAW_STRAY: begin
                stray = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(8'hBF, 8'h80))
                                                    : 8'($urandom_range(8'hFF, 8'hF8));
                content_q.insert($urandom_range(0, content_q.size()), stray);
            end
            default: begin
            end
        endcase
    endtask

    always @(negedge aclk) begin
        int burst_left;
        int gap_left;
        if (aresetn) begin
            if (!s_valid || req_fire) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    s_data <= pending_q.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    sink_mode_t  sink_mode = READY_ALWAYS;
    int          mode_left = 0;
    logic [1:0]  sink_tick = 2'd0;

    always @(negedge aclk) begin
        if (mode_left == 0) begin
            sink_mode = sink_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 96);
        end else begin
            mode_left--;
        end
        sink_tick = sink_tick + 2'd1;
        case (sink_mode)
            READY_ALWAYS: m_ready <= 1'b1;
            READY_COIN:   m_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: m_ready <= (sink_tick == 2'd0);
            default:      m_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge aclk) begin
        u8sv_pkg::out_t want;
        if (!aresetn) begin
            req_fire <= 1'b0;
        end else begin
            req_fire <= s_valid && s_ready;
            if (s_valid && s_ready) track_utf8(s_data);
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result valid=%0b mark=%0d", $time,
                             m_data.content_valid, m_data.mark_length);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_data.content_valid !== want.content_valid ||
                        m_data.mark_length !== want.mark_length) begin
                        fails++;
                        $display("%0t: expected valid=%0b mark=%0d, got valid=%0b mark=%0d",
                                 $time, want.content_valid, want.mark_length,
                                 m_data.content_valid, m_data.mark_length);
                    end
                end
            end
        end
    end

    initial begin
        content_q.delete();
        emit_content(END_APART);
        content_q = '{u8sv_pkg::MARK_BYTE0, u8sv_pkg::MARK_BYTE1, u8sv_pkg::MARK_BYTE2};
        emit_content(END_ON_BYTE);
        content_q = '{u8sv_pkg::MARK_BYTE0, u8sv_pkg::MARK_BYTE1};
        emit_content(END_APART);
        content_q = '{8'h00, 8'h7F, 8'hFF};
        emit_content(END_ON_BYTE);
        content_q = '{8'hC1, 8'hBF};
        emit_content(END_APART);
        content_q = '{8'hED, 8'hA0, 8'h80};
        emit_content(END_ON_BYTE);
        content_q = '{8'hF4, 8'h90, 8'h80, 8'h80};
        emit_content(END_ON_BYTE);
        add_step(8'h5A, 1'b0, 1'b0);
        content_q = '{8'h80};
        emit_content(END_ON_BYTE);
        content_q = '{8'hC2, 8'h41};
        emit_content(END_ON_BYTE);

        while (byte_steps < 1200) begin
            build_content();
            emit_content(END_EITHER);
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() != 0 || s_valid) @(posedge aclk);
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (fails == 0) begin
            $display("[utf8_stream_validator] OK");
        end else begin
            $display("[utf8_stream_validator] ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[utf8_stream_validator] ERROR");
        $finish;
    end

endmodule

/* utf8_stream_validator.f */
+incdir+hdl
hdl/u8sv_pkg.sv
hdl/utf8_stream_validator.sv
verif/tb_utf8_stream_validator.sv
